// File: rtl/core/elgamal_modexp_cipher_top_macros.svh
// Assertion macros for the ElGamal modular exponentiation block
`ifndef ELGAMAL_MODEXP_CIPHER_TOP_MACROS_SVH
`define ELGAMAL_MODEXP_CIPHER_TOP_MACROS_SVH

// check in the same cycle, outside reset
`define EMC_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// check in the next cycle, outside reset
`define EMC_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

// check in the next cycle, reset included
`define EMC_CHK_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/core/emc_pkg.sv
// Package: widths, pipeline geometry, kind codes, register indices and item record
package emc_pkg;

  localparam int W       = 16;
  localparam int SPS     = 2;
  localparam int PAIRS   = W / SPS;
  localparam int ROUNDS  = W + 2;
  localparam int NSTAGE  = ROUNDS * PAIRS;
  localparam int RND_W   = $clog2(ROUNDS);
  localparam int PAIR_W  = $clog2(PAIRS);
  localparam int IDX_W   = $clog2(W);

  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_ENC = 2'd1,
    KIND_DEC = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_GENERATOR = 2'd1,
    REG_PRIVATE = 2'd2,
    REG_PUBLIC = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                zero;
    logic                status;
    logic [W-1:0]        e;
    logic [W-1:0]        msg;
    logic [W-1:0]        c2;
    logic [W-1:0]        ba;
    logic [W-1:0]        aa;
    logic [W-1:0]        bb;
    logic [W-1:0]        ab;
    logic [3:0][W-1:0]   r;
  } emc_item_t;

endpackage

// File: rtl/core/emc_stage.sv
// One pipeline stage: two bit steps of up to four interleaved modular multiplications
module emc_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [emc_pkg::RND_W-1:0]  rnd,
  input  logic [emc_pkg::PAIR_W-1:0] pair,
  input  logic [emc_pkg::W-1:0]      p,
  input  logic                      in_vld,
  input  emc_pkg::emc_item_t        in_item,
  output logic                      out_vld,
  output emc_pkg::emc_item_t        out_item
);
  import emc_pkg::*;

  function automatic logic [W-1:0] mstep(input logic [W-1:0] r, input logic [W-1:0] a,
                                         input logic b, input logic [W-1:0] m);
    logic [W:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    if (b) t = t + {1'b0, a};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[W-1:0];
  endfunction

  emc_item_t it;
  logic [IDX_W-1:0] bp;
  logic [IDX_W-1:0] ei;
  logic vld_r;
  emc_item_t item_r;

  always_comb begin
    it = in_item;
    bp = '0;
    ei = IDX_W'(rnd - RND_W'(1));
    for (int t = 0; t < SPS; t++) begin
      bp = IDX_W'(W - 1 - (int'(pair) * SPS + t));
      if (pair == '0 && t == 0) begin
        it.r = '0;
      end
      if (rnd == '0) begin
        it.r[1] = mstep(it.r[1], W'(1), in_item.ba[bp], p);
        it.r[3] = mstep(it.r[3], W'(1), in_item.bb[bp], p);
      end else if (rnd <= RND_W'(W)) begin
        it.r[0] = mstep(it.r[0], in_item.aa, in_item.ba[bp], p);
        it.r[1] = mstep(it.r[1], in_item.ba, in_item.ba[bp], p);
        it.r[2] = mstep(it.r[2], in_item.ab, in_item.bb[bp], p);
        it.r[3] = mstep(it.r[3], in_item.bb, in_item.bb[bp], p);
      end else begin
        it.r[0] = mstep(it.r[0], in_item.aa, in_item.c2[bp], p);
        it.r[2] = mstep(it.r[2], in_item.ab, in_item.msg[bp], p);
      end
    end
    if (pair == PAIR_W'(PAIRS - 1)) begin
      if (rnd == '0) begin
        it.ba = it.r[1];
        it.bb = it.r[3];
      end else if (rnd <= RND_W'(W)) begin
        if (in_item.e[ei]) begin
          it.aa = it.r[0];
          it.ab = it.r[2];
        end
        it.ba = it.r[1];
        it.bb = it.r[3];
      end else begin
        if (in_item.kind == KIND_DEC) it.aa = it.r[0];
        it.ab = it.r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= it;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// File: rtl/core/elgamal_modexp_cipher_top.sv
// Top level: ElGamal key derivation, encryption and decryption pipeline
//
// Input channel in_* (valid/ready) carries kind, message, nonce and the two
// ciphertext parts; output channel out_* (valid/ready) returns first_value,
// second_value and status, one result per item, in order.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data; write
// only while no item is in flight.
// Every power is right-to-left square-and-multiply; each modular product is
// an interleaved multiply, two bits per stage, over 18 rounds of 16 bits:
// one base reduction, 16 exponent bits, one final product. That gives 144
// stages plus the output register.
// Throughput: one item per cycle unless the output stalls; a new item enters whenever in_ready is high.
// Reset: clears all valid bits and reloads the registers (p=503, g=5,
// x=2, pub=25).
// Stall: while a result waits on out_ready the whole pipeline holds and
// in_ready is low; nothing is lost or repeated.
module elgamal_modexp_cipher_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [emc_pkg::W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [emc_pkg::W-1:0] in_message,
  input  logic [emc_pkg::W-1:0] in_nonce,
  input  logic [emc_pkg::W-1:0] in_cipher_first,
  input  logic [emc_pkg::W-1:0] in_cipher_second,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [emc_pkg::W-1:0] out_first_value,
  output logic [emc_pkg::W-1:0] out_second_value,
  output logic                 out_status
);
  import emc_pkg::*;

  logic [W-1:0] modulus_r, generator_r, private_r, public_r;
  logic en;
  logic bad;
  emc_item_t new_item;
  logic      vld [NSTAGE+1];
  emc_item_t itm [NSTAGE+1];
  logic out_valid_r;
  logic [W-1:0] first_r, second_r;
  logic status_r;
  logic [W-1:0] first_nxt, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= W'(503);
      generator_r <= W'(5);
      private_r   <= W'(2);
      public_r    <= W'(25);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:   modulus_r   <= cfg_data;
        REG_GENERATOR: generator_r <= cfg_data;
        REG_PRIVATE:   private_r   <= cfg_data;
        REG_PUBLIC:    public_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign bad      = ({1'b0, private_r} + (W+1)'(1)) >= {1'b0, modulus_r};

  always_comb begin
    new_item        = '0;
    new_item.kind   = in_kind;
    new_item.msg    = in_message;
    new_item.c2     = in_cipher_second;
    new_item.aa     = W'(1);
    new_item.ab     = W'(1);
    new_item.ba     = generator_r;
    new_item.bb     = public_r;
    new_item.e      = in_nonce;
    case (in_kind)
      KIND_KEY: begin
        new_item.e    = private_r;
        new_item.zero = modulus_r < W'(2);
      end
      KIND_ENC: begin
        new_item.zero = modulus_r < W'(2);
      end
      KIND_DEC: begin
        new_item.ba     = in_cipher_first;
        new_item.e      = modulus_r - W'(1) - private_r;
        new_item.zero   = bad;
        new_item.status = bad;
      end
      default: begin
        new_item.zero = 1'b1;
      end
    endcase
  end

  assign vld[0] = in_valid;
  assign itm[0] = new_item;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    emc_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .rnd      (RND_W'(g / PAIRS)),
      .pair     (PAIR_W'(g % PAIRS)),
      .p        (modulus_r),
      .in_vld   (vld[g]),
      .in_item  (itm[g]),
      .out_vld  (vld[g+1]),
      .out_item (itm[g+1])
    );
  end

  always_comb begin
    first_nxt  = itm[NSTAGE].zero ? '0 : itm[NSTAGE].aa;
    second_nxt = (itm[NSTAGE].zero || itm[NSTAGE].kind != KIND_ENC) ? '0 : itm[NSTAGE].ab;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      status_r <= itm[NSTAGE].status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_status       = status_r;

endmodule

// File: rtl/core/emc_checker.sv
// Port checker for the ElGamal pipeline, bound to the top level
`include "elgamal_modexp_cipher_top_macros.svh"

module emc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [emc_pkg::W-1:0] out_first_value,
  input logic [emc_pkg::W-1:0] out_second_value,
  input logic                  out_status
);
  import emc_pkg::*;

  `EMC_CHK_RST(a_reset_empty, !rst_n, !out_valid)
  `EMC_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_first_value))
  `EMC_CHK_NOW(a_bad_key_zero, out_valid && out_status, (out_first_value | out_second_value) == '0)
  `EMC_CHK_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)

endmodule

bind elgamal_modexp_cipher_top emc_checker u_emc_checker (.*);

// File: sim/tb_top.sv
// Testbench for the ElGamal block: random and directed items checked against a predictor
`timescale 1ns / 100ps

class elgamal_scoreboard;
  logic [15:0] exp_first[$];
  logic [15:0] exp_second[$];
  logic        exp_status[$];
  int          errors;
  int          checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  function void note_item(logic [15:0] f, logic [15:0] s, logic st);
    exp_first.push_back(f);
    exp_second.push_back(s);
    exp_status.push_back(st);
  endfunction

  function int pending();
    return exp_first.size();
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic [15:0] f, logic [15:0] s, logic st);
    logic [15:0] ef;
    logic [15:0] es;
    logic        est;
    if (exp_first.size() == 0) begin
      report($sformatf("unexpected result %0d %0d %0d", f, s, st));
      return;
    end
    ef = exp_first.pop_front();
    es = exp_second.pop_front();
    est = exp_status.pop_front();
    checked++;
    if (f !== ef) report($sformatf("first_value got %0d want %0d", f, ef));
    if (s !== es) report($sformatf("second_value got %0d want %0d", s, es));
    if (st !== est) report($sformatf("status got %0d want %0d", st, est));
  endtask
endclass

module tb_top;
  import emc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [15:0] in_message;
  logic [15:0] in_nonce;
  logic [15:0] in_cipher_first;
  logic [15:0] in_cipher_second;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_first_value;
  logic [15:0] out_second_value;
  logic        out_status;

  logic [15:0] p_mod;
  logic [15:0] p_gen;
  logic [15:0] p_priv;
  logic [15:0] p_pub;

  elgamal_scoreboard sb;
  int idle_cycles;
  int stall_mode;
  int sent;
  int kind_seen[4];

  localparam int IDLE_LIMIT = 20000;

  elgamal_modexp_cipher_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] mod_power(logic [15:0] e, logic [15:0] b, logic [15:0] m);
    logic [63:0] base;
    logic [63:0] acc;
    logic [15:0] ex;
    base = b % m;
    acc = 1 % m;
    ex = e;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      ex = ex >> 1;
    end
    return acc[15:0];
  endfunction

  task automatic predict_cipher(logic [1:0] k, logic [15:0] m, logic [15:0] n,
                                logic [15:0] c1, logic [15:0] c2);
    logic [63:0] f;
    logic [63:0] s;
    logic        st;
    f = 0;
    s = 0;
    st = 1'b0;
    case (kind_t'(k))
      KIND_KEY: if (p_mod >= 2) f = 64'(mod_power(p_priv, p_gen, p_mod));
      KIND_ENC: if (p_mod >= 2) begin
        f = 64'(mod_power(n, p_gen, p_mod));
        s = ((m % p_mod) * mod_power(n, p_pub, p_mod)) % p_mod;
      end
      KIND_DEC: if ({1'b0, p_priv} + 17'd1 >= {1'b0, p_mod}) st = 1'b1;
        else f = (mod_power(p_mod - 16'd1 - p_priv, c1, p_mod) * (c2 % p_mod)) % p_mod;
      default: ;
    endcase
    sb.note_item(f[15:0], s[15:0], st);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_first_value, out_second_value, out_status);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired");
        $display("** elgamal_modexp_cipher_top: FAILED **");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS: p_mod = val;
      REG_GENERATOR: p_gen = val;
      REG_PRIVATE: p_priv = val;
      default: p_pub = val;
    endcase
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] k, logic [15:0] m, logic [15:0] n,
                           logic [15:0] c1, logic [15:0] c2);
    in_valid <= 1'b1;
    in_kind <= k;
    in_message <= m;
    in_nonce <= n;
    in_cipher_first <= c1;
    in_cipher_second <= c2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cipher(k, m, n, c1, c2);
    kind_seen[k]++;
    sent++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 20)) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 15));
      3: return p_mod - 16'($urandom_range(0, 2));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_phase(int count);
    int left;
    int burst;
    logic [1:0] k;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && left > 0) begin
        k = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
        send_item(k, rnd16(), rnd16(), rnd16(), rnd16());
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    stall_mode = 0;
    sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_KEY;
    in_message = '0;
    in_nonce = '0;
    in_cipher_first = '0;
    in_cipher_second = '0;
    p_mod = 16'd503;
    p_gen = 16'd5;
    p_priv = 16'd2;
    p_pub = 16'd25;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_KEY, 0, 0, 0, 0);
    send_item(KIND_ENC, 16'hffff, 16'hffff, 0, 0);
    send_item(KIND_ENC, 100, 0, 0, 0);
    send_item(KIND_ENC, 503, 7, 0, 0);
    send_item(KIND_DEC, 0, 0, 16'hffff, 16'hffff);
    send_item(KIND_DEC, 0, 0, 0, 0);
    send_item(KIND_DEC, 0, 0, 503, 1000);
    send_item(KIND_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_PRIVATE, 16'd501);
    send_item(KIND_DEC, 0, 0, 3, 4);
    send_item(KIND_KEY, 0, 0, 0, 0);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_MODULUS, 16'd1);
    send_item(KIND_KEY, 0, 0, 0, 0);
    send_item(KIND_ENC, 9, 9, 0, 0);
    send_item(KIND_DEC, 0, 0, 9, 9);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_MODULUS, 16'd0);
    send_item(KIND_ENC, 9, 9, 0, 0);
    send_item(KIND_DEC, 0, 0, 9, 9);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 4;
      case (ph)
        0: begin
          write_reg(REG_MODULUS, 16'd65521);
          write_reg(REG_GENERATOR, 16'd17);
          write_reg(REG_PRIVATE, 16'd12345);
          write_reg(REG_PUBLIC, mod_power(16'd12345, 16'd17, 16'd65521));
        end
        1: begin
          write_reg(REG_MODULUS, 16'd65535);
          write_reg(REG_GENERATOR, 16'hffff);
          write_reg(REG_PRIVATE, 16'd65533);
          write_reg(REG_PUBLIC, 16'hffff);
        end
        2: begin
          write_reg(REG_MODULUS, 16'd5);
          write_reg(REG_GENERATOR, 16'd2);
          write_reg(REG_PRIVATE, 16'd0);
          write_reg(REG_PUBLIC, 16'd0);
        end
        default: begin
          write_reg(REG_MODULUS, 16'($urandom_range(5, 65535)));
          write_reg(REG_GENERATOR, 16'($urandom()));
          write_reg(REG_PRIVATE, 16'($urandom_range(0, p_mod)));
          write_reg(REG_PUBLIC, 16'($urandom()));
        end
      endcase
      random_phase(105);
      drain();
    end

    $display("covered %0d items: key %0d, encrypt %0d, decrypt %0d, unused %0d",
             sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("checked %0d results over several register settings and stall patterns",
             sb.checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** elgamal_modexp_cipher_top: PASSED **");
    else
      $display("** elgamal_modexp_cipher_top: FAILED **");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/emc_pkg.sv
rtl/core/emc_stage.sv
rtl/core/elgamal_modexp_cipher_top.sv
rtl/core/emc_checker.sv
sim/tb_top.sv
